>>> hdl/nlt_pkg.sv
// ----------------------------------------------------------------------------
// nlt_pkg
// Types and constants shared by the neighbour liveness table and its cells.
// ----------------------------------------------------------------------------
package nlt_pkg;

    // command codes
    localparam logic [1:0] CMD_ADD      = 2'd0;
    localparam logic [1:0] CMD_RECEIVED = 2'd1;
    localparam logic [1:0] CMD_MISSED   = 2'd2;

    // status codes
    localparam logic [1:0] ST_ADDED     = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_UPDATED   = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // configuration register indexes
    localparam logic CFG_CAPACITY   = 1'b0;
    localparam logic CFG_MISS_LIMIT = 1'b1;

    localparam int CAP_W   = 5;
    localparam int LIMIT_W = 4;

    localparam logic [CAP_W-1:0]   CAPACITY_RESET   = 5'd16;
    localparam logic [LIMIT_W-1:0] MISS_LIMIT_RESET = 4'd3;
    localparam logic [3:0]         MISS_SAT         = 4'd15;

    // request travelling along the row of cells
    typedef struct packed {
        logic               valid;
        logic [1:0]         cmd;
        logic [31:0]        node_id;
        logic signed [31:0] seq_number;
        logic [31:0]        metrics_handle;
        logic               placed;   // an add has found its slot (or was refused)
    } t_req;

endpackage

>>> hdl/nlt_cell.sv
// ----------------------------------------------------------------------------
// nlt_cell
// One table entry: checks the passing request against its entry, updates it
// and hands the request and running match count on to the next cell.
// ----------------------------------------------------------------------------
module nlt_cell #(
    parameter int CNT_W = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [nlt_pkg::LIMIT_W-1:0]  i_miss_limit,
    input  nlt_pkg::t_req                i_req,
    input  logic [CNT_W-1:0]             i_cnt,
    output nlt_pkg::t_req                o_req,
    output logic [CNT_W-1:0]             o_cnt
);

    logic               r_used, n_used;
    logic               r_active, n_active;
    logic [31:0]        r_id, n_id;
    logic [31:0]        r_handle, n_handle;
    logic signed [31:0] r_seq, n_seq;
    logic [3:0]         r_miss, n_miss;
    nlt_pkg::t_req      r_req, n_req;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    logic       hit;
    logic       take;
    logic [3:0] miss_inc;

    assign hit  = i_req.valid && r_used && (r_id == i_req.node_id)
                  && (i_req.cmd == nlt_pkg::CMD_RECEIVED || i_req.cmd == nlt_pkg::CMD_MISSED);
    assign take = i_req.valid && (i_req.cmd == nlt_pkg::CMD_ADD) && !r_used && !i_req.placed;
    assign miss_inc = (r_miss == nlt_pkg::MISS_SAT) ? r_miss : r_miss + 4'd1;

    always_comb begin
        n_used   = r_used;
        n_active = r_active;
        n_id     = r_id;
        n_handle = r_handle;
        n_seq    = r_seq;
        n_miss   = r_miss;
        n_req    = i_req;
        n_cnt    = i_cnt;
        if (take) begin
            n_used       = 1'b1;
            n_active     = 1'b1;
            n_id         = i_req.node_id;
            n_handle     = i_req.metrics_handle;
            n_seq        = i_req.seq_number;
            n_miss       = 4'd0;
            n_req.placed = 1'b1;
        end else if (hit) begin
            n_cnt = i_cnt + CNT_W'(1);
            case (i_req.cmd)
                nlt_pkg::CMD_RECEIVED: begin
                    if (i_req.seq_number > r_seq) begin
                        n_handle = i_req.metrics_handle;
                        n_seq    = i_req.seq_number;
                    end
                    n_miss   = 4'd0;
                    n_active = 1'b1;
                end
                default: begin
                    n_miss = miss_inc;
                    if (miss_inc >= i_miss_limit) begin
                        n_active = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= 1'b0;
            r_active <= 1'b0;
            r_req    <= '0;
        end else begin
            r_used   <= n_used;
            r_active <= n_active;
            r_req    <= n_req;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id     <= n_id;
        r_handle <= n_handle;
        r_seq    <= n_seq;
        r_miss   <= n_miss;
        r_cnt    <= n_cnt;
    end

    assign o_req = r_req;
    assign o_cnt = r_cnt;

endmodule

>>> hdl/neighbor_liveness_table.sv
// ----------------------------------------------------------------------------
// neighbor_liveness_table
// Heartbeat liveness table of peer entries, one entry per cell in a row.
// ----------------------------------------------------------------------------
//
// Channel    Direction  Handshake               Payload
// request    in         start & !busy           i_command, i_node_id,
//                                               i_seq_number, i_metrics_handle
// result     out        o_done (one cycle)      o_status, o_match_count,
//                                               o_entry_count
// config     in         i_cfg_we                i_cfg_idx, i_cfg_data
//
// A request enters the first cell at the accepting edge and moves one cell
// per cycle; once it has left the last cell its result is registered and
// the strobe rises. busy stays high until then, so only one request is in
// the row at a time and a new request waits for the whole cell row. busy
// falls as the result is registered, so the next request may be taken in
// the cycle the result is shown.
// Reset clears the fill count, the used and active flags of every cell and
// loads capacity 16 and miss limit 3; entry contents are left as they are.
// The receiver cannot stall: o_done is high for exactly one cycle per result; the payload is held until the next.
// ----------------------------------------------------------------------------
module neighbor_liveness_table #(
    parameter int MAX_NEIGHBORS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_node_id,
    input  logic signed [31:0] i_seq_number,
    input  logic [31:0] i_metrics_handle,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [4:0]  o_match_count,
    output logic [4:0]  o_entry_count,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [4:0]  i_cfg_data
);

    // counts of up to MAX_NEIGHBORS entries
    localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
    // common width for the fill-level compares
    localparam int CMP_W = (CNT_W > nlt_pkg::CAP_W) ? CNT_W : nlt_pkg::CAP_W;
    localparam logic [CMP_W-1:0] MAX_FILL = CMP_W'(MAX_NEIGHBORS);

    logic                        r_busy, n_busy;
    logic [CNT_W-1:0]            r_used, n_used;
    logic [nlt_pkg::CAP_W-1:0]   r_capacity;
    logic [nlt_pkg::LIMIT_W-1:0] r_miss_limit;
    logic                        r_full, n_full;
    logic                        r_done, n_done;
    logic [1:0]                  r_status, n_status;
    logic [4:0]                  r_match, n_match;
    logic [4:0]                  r_entry, n_entry;

    logic          accept;
    logic          full_now;
    nlt_pkg::t_req head_req;

    nlt_pkg::t_req    chain_req [0:MAX_NEIGHBORS];
    logic [CNT_W-1:0] chain_cnt [0:MAX_NEIGHBORS];

    assign accept = start && !r_busy;

    // full when the fill level reaches capacity or the number of cells
    assign full_now = (CMP_W'(r_used) >= CMP_W'(r_capacity)) || (CMP_W'(r_used) >= MAX_FILL);

    // build the request that enters the first cell; a refused add is
    // marked placed already so no cell takes it
    always_comb begin
        head_req.valid          = accept;
        head_req.cmd            = i_command;
        head_req.node_id        = i_node_id;
        head_req.seq_number     = i_seq_number;
        head_req.metrics_handle = i_metrics_handle;
        head_req.placed         = (i_command == nlt_pkg::CMD_ADD) && full_now;
    end

    assign chain_req[0] = head_req;
    assign chain_cnt[0] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_NEIGHBORS; g = g + 1) begin : g_cell
            nlt_cell #(
                .CNT_W (CNT_W)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_miss_limit (r_miss_limit),
                .i_req        (chain_req[g]),
                .i_cnt        (chain_cnt[g]),
                .o_req        (chain_req[g+1]),
                .o_cnt        (chain_cnt[g+1])
            );
        end
    endgenerate

    always_comb begin
        n_busy   = r_busy;
        n_used   = r_used;
        n_full   = r_full;
        n_done   = 1'b0;
        n_status = r_status;
        n_match  = r_match;
        n_entry  = r_entry;

        // take a request: count an accepted add straight away
        if (accept) begin
            n_busy = 1'b1;
            n_full = full_now;
            if (i_command == nlt_pkg::CMD_ADD && !full_now) begin
                n_used = r_used + CNT_W'(1);
            end
        end

        // request has left the last cell: register the result, drop busy
        if (chain_req[MAX_NEIGHBORS].valid) begin
            n_busy  = 1'b0;
            n_done  = 1'b1;
            n_match = 5'(chain_cnt[MAX_NEIGHBORS]);
            n_entry = 5'(r_used);
            case (chain_req[MAX_NEIGHBORS].cmd)
                nlt_pkg::CMD_ADD: begin
                    n_status = r_full ? nlt_pkg::ST_FULL : nlt_pkg::ST_ADDED;
                end
                nlt_pkg::CMD_RECEIVED, nlt_pkg::CMD_MISSED: begin
                    n_status = (chain_cnt[MAX_NEIGHBORS] != '0) ? nlt_pkg::ST_UPDATED
                                                                : nlt_pkg::ST_NOT_FOUND;
                end
                default: begin
                    n_status = nlt_pkg::ST_NOT_FOUND;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_used       <= '0;
            r_done       <= 1'b0;
            r_capacity   <= nlt_pkg::CAPACITY_RESET;
            r_miss_limit <= nlt_pkg::MISS_LIMIT_RESET;
        end else begin
            r_busy <= n_busy;
            r_used <= n_used;
            r_done <= n_done;
            // write a register at once; the sender must keep writes to idle periods, the block does not enforce it
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    nlt_pkg::CFG_CAPACITY:   r_capacity   <= i_cfg_data;
                    nlt_pkg::CFG_MISS_LIMIT: r_miss_limit <= i_cfg_data[nlt_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // result payload, held between strobes
    always_ff @(posedge i_clk) begin
        r_full   <= n_full;
        r_status <= n_status;
        r_match  <= n_match;
        r_entry  <= n_entry;
    end

    assign busy          = r_busy;
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_match_count = r_match;
    assign o_entry_count = r_entry;

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the neighbour liveness table. A tracker class keeps
// its own copy of the peer table and the two registers, works out the reply
// to every accepted request and compares it with what the block returns.
// ----------------------------------------------------------------------------
module tb;

    localparam int          TABLE_DEPTH = 16;
    localparam int          LATENCY     = TABLE_DEPTH + 1;
    localparam int          STALL_LIMIT = 1000;
    localparam int          SHOW_LIMIT  = 10;
    // the fourth command code has no name in the package; it must do nothing
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] match_cnt;
        logic [4:0] entries;
    } t_reply;

    // Shadow of the peer table: apply each accepted request, queue its reply,
    // and check the replies from the block in order.
    class peer_table_tracker;
        logic [31:0]        ids     [TABLE_DEPTH];
        logic [31:0]        handles [TABLE_DEPTH];
        logic signed [31:0] seqs    [TABLE_DEPTH];
        logic [3:0]         misses  [TABLE_DEPTH];
        bit                 live    [TABLE_DEPTH];
        int unsigned        fill;
        logic [4:0]         capacity;
        logic [3:0]         miss_limit;
        t_reply             expected_replies[$];
        int unsigned        mismatches;

        function new();
            fill       = 0;
            capacity   = nlt_pkg::CAPACITY_RESET;
            miss_limit = nlt_pkg::MISS_LIMIT_RESET;
            mismatches = 0;
            foreach (live[i]) live[i] = 1'b0;
        endfunction

        function void set_register(logic idx, logic [4:0] value);
            if (idx == nlt_pkg::CFG_CAPACITY) begin
                capacity = value;
            end else begin
                miss_limit = value[3:0];
            end
        endfunction

        function void apply_request(logic [1:0] cmd, logic [31:0] id,
                                    logic signed [31:0] seq, logic [31:0] handle);
            int unsigned room;
            t_reply      r;
            room        = (capacity < TABLE_DEPTH) ? capacity : TABLE_DEPTH;
            r.status    = nlt_pkg::ST_NOT_FOUND;
            r.match_cnt = '0;
            case (cmd)
                nlt_pkg::CMD_ADD: begin
                    if (fill >= room) begin
                        r.status = nlt_pkg::ST_FULL;
                    end else begin
                        ids[fill]     = id;
                        handles[fill] = handle;
                        seqs[fill]    = seq;
                        misses[fill]  = '0;
                        live[fill]    = 1'b1;
                        fill++;
                        r.status = nlt_pkg::ST_ADDED;
                    end
                end
                nlt_pkg::CMD_RECEIVED, nlt_pkg::CMD_MISSED: begin
                    for (int i = 0; i < fill; i++) begin
                        if (ids[i] == id) begin
                            r.match_cnt++;
                            if (cmd == nlt_pkg::CMD_RECEIVED) begin
                                // only a strictly newer sequence number wins
                                if (seq > seqs[i]) begin
                                    seqs[i]    = seq;
                                    handles[i] = handle;
                                end
                                misses[i] = '0;
                                live[i]   = 1'b1;
                            end else begin
                                if (misses[i] != nlt_pkg::MISS_SAT) misses[i]++;
                                if (misses[i] >= miss_limit) live[i] = 1'b0;
                            end
                        end
                    end
                    if (r.match_cnt != 0) r.status = nlt_pkg::ST_UPDATED;
                end
                default: ;
            endcase
            r.entries = fill[4:0];
            expected_replies.push_back(r);
        endfunction

        function void check_result(logic [1:0] status, logic [4:0] match_cnt,
                                   logic [4:0] entries);
            t_reply want;
            if (expected_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("unexpected reply: status %0d matched %0d entries %0d",
                             status, match_cnt, entries);
                return;
            end
            want = expected_replies.pop_front();
            if (status !== want.status || match_cnt !== want.match_cnt ||
                entries !== want.entries) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("reply error: status %0d/%0d matched %0d/%0d entries %0d/%0d %s",
                             want.status, status, want.match_cnt, match_cnt,
                             want.entries, entries, "(expected/actual)");
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_command;
    logic [31:0]        i_node_id;
    logic signed [31:0] i_seq_number;
    logic [31:0]        i_metrics_handle;
    logic               o_done;
    logic [1:0]         o_status;
    logic [4:0]         o_match_count;
    logic [4:0]         o_entry_count;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [4:0]         i_cfg_data;

    peer_table_tracker  tracker = new();
    int unsigned        quiet_cycles;

    neighbor_liveness_table #(
        .MAX_NEIGHBORS(TABLE_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_node_id       (i_node_id),
        .i_seq_number    (i_seq_number),
        .i_metrics_handle(i_metrics_handle),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_match_count   (o_match_count),
        .o_entry_count   (o_entry_count),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Check every reply on the edge that ends its strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) tracker.check_result(o_status, o_match_count, o_entry_count);
    end

    // Watchdog: count edges at which neither a request nor a reply moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Present a request at the falling edge and hold it until the block takes
    // it; leave start high so a following request can go straight in.
    task automatic send_request(input logic [1:0] cmd, input logic [31:0] id,
                                input logic [31:0] seq, input logic [31:0] handle);
        @(negedge i_clk);
        start            = 1'b1;
        i_command        = cmd;
        i_node_id        = id;
        i_seq_number     = seq;
        i_metrics_handle = handle;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.apply_request(cmd, id, seq, handle);
    endtask

    // Drop start at the next falling edge, then wait the given number of extra cycles.
    task automatic hold_off(input int unsigned extra);
        @(negedge i_clk);
        start = 1'b0;
        repeat (extra) @(negedge i_clk);
    endtask

    // Stop sending and wait until every outstanding reply has come back.
    task automatic drain;
        @(negedge i_clk);
        start = 1'b0;
        while (tracker.expected_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [4:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(posedge i_clk);
        tracker.set_register(idx, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Mostly heartbeats for peers already in the table, some adds (a third of
    // them duplicates), and a little noise: unknown ids and the unused code.
    task automatic random_request;
        int unsigned pick;
        int unsigned slot;
        logic [1:0]  cmd;
        logic [31:0] id;
        logic [31:0] seq;
        logic [31:0] handle;
        pick   = $urandom_range(99);
        id     = $urandom;
        seq    = $urandom;
        handle = $urandom;
        if (pick < 15 || tracker.fill == 0) begin
            cmd = nlt_pkg::CMD_ADD;
            if (tracker.fill != 0 && $urandom_range(2) == 0)
                id = tracker.ids[$urandom_range(tracker.fill - 1)];
        end else if (pick < 92) begin
            cmd = (pick < 50) ? nlt_pkg::CMD_RECEIVED : nlt_pkg::CMD_MISSED;
            if ($urandom_range(9) != 0) begin
                slot = $urandom_range(tracker.fill - 1);
                id   = tracker.ids[slot];
                // land near the stored number so both sides of the compare occur
                if ($urandom_range(1) == 1) seq = tracker.seqs[slot] + $urandom_range(8) - 4;
            end
        end else begin
            cmd = CMD_UNUSED;
        end
        send_request(cmd, id, seq, handle);
    endtask

    // One configuration setting followed by a run of random requests; half
    // way through, pause until the block has answered everything.
    task automatic run_phase(input logic [4:0] cap, input logic [3:0] limit,
                             input int unsigned count, input bit idling);
        drain();
        write_register(nlt_pkg::CFG_CAPACITY, cap);
        write_register(nlt_pkg::CFG_MISS_LIMIT, {1'b0, limit});
        for (int unsigned n = 0; n < count; n++) begin
            if (n == count / 2) drain();
            random_request();
            if (idling && $urandom_range(99) < 34) hold_off($urandom_range(19));
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_command        = nlt_pkg::CMD_ADD;
        i_node_id        = '0;
        i_seq_number     = '0;
        i_metrics_handle = '0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = nlt_pkg::CFG_CAPACITY;
        i_cfg_data       = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Zero capacity: every add is refused, heartbeats find nothing.
        write_register(nlt_pkg::CFG_CAPACITY, 5'd0);
        write_register(nlt_pkg::CFG_MISS_LIMIT, 5'd0);
        send_request(nlt_pkg::CMD_ADD, $urandom, $urandom, $urandom);
        send_request(nlt_pkg::CMD_RECEIVED, $urandom, $urandom, $urandom);
        send_request(nlt_pkg::CMD_MISSED, $urandom, $urandom, $urandom);
        send_request(CMD_UNUSED, $urandom, $urandom, $urandom);

        // One entry at the lowest sequence number, then the compare edges:
        // equal, highest, minus one. Zero miss limit ages out on the first miss.
        drain();
        write_register(nlt_pkg::CFG_CAPACITY, 5'd1);
        send_request(nlt_pkg::CMD_ADD, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000);
        send_request(nlt_pkg::CMD_ADD, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
        send_request(nlt_pkg::CMD_RECEIVED, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(nlt_pkg::CMD_RECEIVED, 32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(nlt_pkg::CMD_RECEIVED, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(nlt_pkg::CMD_MISSED, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(nlt_pkg::CMD_MISSED, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);

        // Duplicate ids are accepted and each copy counts as a match.
        drain();
        write_register(nlt_pkg::CFG_CAPACITY, 5'd4);
        write_register(nlt_pkg::CFG_MISS_LIMIT, 5'd15);
        send_request(nlt_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(nlt_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_request(nlt_pkg::CMD_ADD, 32'h0000_0000, 32'h8000_0000, 32'h1234_5678);
        send_request(nlt_pkg::CMD_MISSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(nlt_pkg::CMD_RECEIVED, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
        send_request(nlt_pkg::CMD_ADD, $urandom, $urandom, $urandom);
        send_request(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Random phases; the capacity of 2 sits below the fill level reached
        // by then, and the third phase runs without random pauses.
        run_phase(5'd6,  4'd3,  150, 1'b1);
        run_phase(5'd2,  4'd5,  100, 1'b1);
        run_phase(5'd16, 4'd1,  250, 1'b0);
        run_phase(5'd31, 4'd15, 250, 1'b1);
        run_phase(5'd20, 4'd0,  200, 1'b1);
        run_phase(5'd16, 4'd7,  350, 1'b1);

        drain();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.expected_replies.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
